// ----- rtl/aifp_pkg.sv -----
// Shared types, codes and character helpers for the ASCII integer field parser.
`timescale 1ns / 1ps

package aifp_pkg;

    localparam int MAX_WIDTH_BITS_DEF = 8;
    localparam int VALUE_W            = 64;
    localparam int S_TDATA_W          = 8;
    localparam int S_TUSER_W          = 1;
    localparam int M_TDATA_W          = 80;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 8;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_FIRST,
        PH_PREFIX,
        PH_DIGITS
    } phase_t;

    // conversion kinds
    localparam logic [2:0] KIND_SDEC  = 3'd0;
    localparam logic [2:0] KIND_SAUTO = 3'd1;
    localparam logic [2:0] KIND_OCT   = 3'd2;
    localparam logic [2:0] KIND_UDEC  = 3'd3;
    localparam logic [2:0] KIND_HEX   = 3'd4;

    // field status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_EOF  = 2'd2;

    // result sizes
    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KIND  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE  = 2'd2;

    // characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // radix codes; auto means not yet decided
    localparam logic [4:0] RADIX_AUTO = 5'd0;
    localparam logic [4:0] RADIX_8    = 5'd8;
    localparam logic [4:0] RADIX_10   = 5'd10;
    localparam logic [4:0] RADIX_16   = 5'd16;

    localparam logic [5:0] DIGIT_NONE = 6'd63;

    typedef struct packed {
        logic [7:0]         used;
        logic               consumed;
        logic [1:0]         status;
        logic [VALUE_W-1:0] value;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Digit value of a letter or number; DIGIT_NONE is above every radix.
    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h57;
        end else begin
            d = 8'(DIGIT_NONE);
        end
        return d[5:0];
    endfunction

endpackage

// ----- rtl/ascii_integer_field_parser_unit.sv -----
// Top level of the ASCII integer field parser: character stream in, one result per field out.
`timescale 1ns / 1ps

// Parses scanf-style integer fields from a stream of ASCII characters, one character
// (or an end-of-input mark in s_tuser) per word. Every accepted word is fully processed
// in the cycle it is taken: the parse state and, when a field ends, the result register
// or the skid entry are updated at that edge, so the block sustains one input word per
// clock. The output side has a register plus one skid entry, so input flows on while a
// result waits; input stalls only when both are full. A result with char_consumed low
// asks the source to present the same character again as the start of the next field.
// Configuration writes are expected only while the block is idle.
module ascii_integer_field_parser_unit #(
    parameter int MAX_WIDTH_BITS = aifp_pkg::MAX_WIDTH_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [aifp_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] char_code
    input  logic [aifp_pkg::S_TUSER_W-1:0]     s_tuser,   // [0] input end mark

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [63:0] field_value, [65:64] field_status, [66] char_consumed,
    // [74:67] chars_used, [79:75] zero
    output logic [aifp_pkg::M_TDATA_W-1:0]     m_tdata,

    input  logic                               cfg_wr_en,
    input  logic [aifp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [aifp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import aifp_pkg::*;

    localparam int CNT_W = MAX_WIDTH_BITS;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // configuration
    logic [2:0] kind_reg;
    logic [7:0] width_reg;
    logic [1:0] size_reg;

    // parse state
    phase_t             phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [4:0]         radix_reg, radix_next;
    logic               seen_reg, seen_next;

    // output register and skid entry
    logic    m_valid_reg, m_valid_next;
    result_t out_reg, out_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg, skid_next;

    logic       s_accept;
    logic [7:0] c;
    logic       eof;
    logic       signed_kind;
    logic [4:0] base_radix;
    logic [5:0] dig;

    logic [CNT_W-1:0] fs_cnt, fs_inc, d_inc;
    logic [4:0]       fs_radix, fs_radix_dec;
    logic             fs_dig_ok, d_dig_ok;
    logic             lim_fs, lim_d;
    logic [VALUE_W-1:0] mac;

    logic   ev_emit, ev_fin, ev_consumed, do_first, do_digits;
    logic [1:0] ev_status;
    phase_t go_phase;

    logic [VALUE_W-1:0] signed_val, sized_val;
    logic [CMP_W-1:0]   cnt_wide;
    result_t            res;
    logic               new_valid;

    assign s_accept = s_tvalid && s_tready;
    assign c        = s_tdata[7:0];
    assign eof      = s_tuser[0];
    assign dig      = digit_of(c);

    always_comb begin
        unique case (kind_reg)
            KIND_SAUTO: base_radix = RADIX_AUTO;
            KIND_OCT:   base_radix = RADIX_8;
            KIND_HEX:   base_radix = RADIX_16;
            default:    base_radix = RADIX_10;
        endcase
    end
    assign signed_kind = (kind_reg == KIND_SDEC) || (kind_reg == KIND_SAUTO);

    // first-character view: a fresh field when coming from the skip phase
    assign fs_cnt       = (phase_reg == PH_SKIP) ? '0 : cnt_reg;
    assign fs_radix     = (phase_reg == PH_SKIP) ? base_radix : radix_reg;
    assign fs_radix_dec = (fs_radix == RADIX_AUTO) ? RADIX_10 : fs_radix;
    assign fs_inc       = (&fs_cnt) ? fs_cnt : fs_cnt + 1'b1;
    assign d_inc        = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
    assign fs_dig_ok    = dig < {1'b0, fs_radix_dec};
    assign d_dig_ok     = dig < {1'b0, radix_reg};
    assign lim_fs       = (width_reg != 8'd0) && (CMP_W'(fs_inc) >= CMP_W'(width_reg));
    assign lim_d        = (width_reg != 8'd0) && (CMP_W'(d_inc) >= CMP_W'(width_reg));

    // acc * radix + digit with shifts and adds
    always_comb begin
        case (radix_reg)
            RADIX_16: mac = (acc_reg << 4) + VALUE_W'(dig);
            RADIX_10: mac = (acc_reg << 3) + (acc_reg << 1) + VALUE_W'(dig);
            default:  mac = (acc_reg << 3) + VALUE_W'(dig);
        endcase
    end

    // datapath step and field events
    always_comb begin
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        radix_next  = radix_reg;
        seen_next   = seen_reg;
        ev_emit     = 1'b0;
        ev_fin      = 1'b0;
        ev_consumed = 1'b0;
        ev_status   = ST_FAIL;
        go_phase    = phase_reg;
        do_first    = 1'b0;
        do_digits   = 1'b0;

        unique case (phase_reg)
            PH_SKIP: begin
                if (eof) begin
                    cnt_next  = '0;
                    ev_emit   = 1'b1;
                    ev_status = ST_EOF;
                end else if (!is_space(c)) begin
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    cnt_next   = '0;
                    seen_next  = 1'b0;
                    radix_next = base_radix;
                    if (signed_kind && (c == CH_MINUS || c == CH_PLUS)) begin
                        neg_next = (c == CH_MINUS);
                        cnt_next = fs_inc;
                        if (lim_fs) begin
                            ev_emit     = 1'b1;
                            ev_consumed = 1'b1;
                        end else begin
                            go_phase = PH_FIRST;
                        end
                    end else begin
                        do_first = 1'b1;
                    end
                end
            end
            PH_FIRST: begin
                if (eof) begin
                    ev_emit   = 1'b1;
                    ev_status = (cnt_reg != '0) ? ST_FAIL : ST_EOF;
                end else begin
                    do_first = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (eof) begin
                    ev_emit = 1'b1;
                    ev_fin  = 1'b1;
                end else if (c == CH_LOW_X || c == CH_UP_X) begin
                    cnt_next   = d_inc;
                    radix_next = RADIX_16;
                    seen_next  = 1'b0;
                    if (lim_d) begin
                        ev_emit     = 1'b1;
                        ev_fin      = 1'b1;
                        ev_consumed = 1'b1;
                    end else begin
                        go_phase = PH_DIGITS;
                    end
                end else begin
                    do_digits = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (eof) begin
                    ev_emit = 1'b1;
                    ev_fin  = 1'b1;
                end else begin
                    do_digits = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_first) begin
            if (fs_radix == RADIX_AUTO && c == CH_ZERO) begin
                cnt_next   = fs_inc;
                radix_next = RADIX_8;
                seen_next  = 1'b1;
                if (lim_fs) begin
                    ev_emit     = 1'b1;
                    ev_fin      = 1'b1;
                    ev_consumed = 1'b1;
                end else begin
                    go_phase = PH_PREFIX;
                end
            end else begin
                radix_next = fs_radix_dec;
                if (!fs_dig_ok) begin
                    ev_emit = 1'b1;
                end else begin
                    acc_next  = VALUE_W'(dig);
                    seen_next = 1'b1;
                    cnt_next  = fs_inc;
                    if (lim_fs) begin
                        ev_emit     = 1'b1;
                        ev_fin      = 1'b1;
                        ev_consumed = 1'b1;
                    end else begin
                        go_phase = PH_DIGITS;
                    end
                end
            end
        end

        if (do_digits) begin
            if (!d_dig_ok) begin
                ev_emit = 1'b1;
                ev_fin  = 1'b1;
            end else begin
                acc_next  = mac;
                seen_next = 1'b1;
                cnt_next  = d_inc;
                if (lim_d) begin
                    ev_emit     = 1'b1;
                    ev_fin      = 1'b1;
                    ev_consumed = 1'b1;
                end else begin
                    go_phase = PH_DIGITS;
                end
            end
        end
    end

    // next phase: back to skipping once a field is reported
    always_comb begin
        phase_next = phase_reg;
        if (s_accept) begin
            phase_next = ev_emit ? PH_SKIP : go_phase;
        end
    end

    // result word
    always_comb begin
        signed_val = neg_next ? (~acc_next + 1'b1) : acc_next;
        case (size_reg)
            SIZE_BYTE: sized_val = {{(VALUE_W-8){1'b0}},  signed_val[7:0]};
            SIZE_HALF: sized_val = {{(VALUE_W-16){1'b0}}, signed_val[15:0]};
            SIZE_WORD: sized_val = {{(VALUE_W-32){1'b0}}, signed_val[31:0]};
            default:   sized_val = signed_val;
        endcase
        cnt_wide     = CMP_W'(cnt_next);
        res.status   = ev_fin ? (seen_next ? ST_OK : ST_FAIL) : ev_status;
        res.consumed = ev_consumed;
        res.value    = (res.status == ST_OK) ? sized_val : '0;
        if (res.status == ST_EOF) begin
            res.used = 8'd0;
        end else if (cnt_wide > CMP_W'(255)) begin
            res.used = 8'hFF;
        end else begin
            res.used = cnt_wide[7:0];
        end
    end

    assign new_valid = s_accept && ev_emit;

    // output register with one skid entry
    always_comb begin
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = new_valid;
                out_next     = res;
            end
        end else if (new_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg  <= KIND_SDEC;
            width_reg <= 8'd0;
            size_reg  <= SIZE_WORD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KIND:  kind_reg  <= cfg_wdata[2:0];
                REG_WIDTH: width_reg <= cfg_wdata[7:0];
                REG_SIZE:  size_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SKIP;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            cnt_reg        <= '0;
            radix_reg      <= RADIX_AUTO;
            seen_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (s_accept) begin
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                cnt_reg   <= cnt_next;
                radix_reg <= radix_next;
                seen_reg  <= seen_next;
            end
        end
    end

    // payload holds need no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

// ----- rtl/aifp_checker.sv -----
// Port-level checks for the ASCII integer field parser, bound to the top level.
`timescale 1ns / 1ps

module aifp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [aifp_pkg::M_TDATA_W-1:0]   m_tdata
);
    import aifp_pkg::*;

    logic [1:0] status;
    logic       consumed;
    logic [7:0] used;

    assign status   = m_tdata[65:64];
    assign consumed = m_tdata[66];
    assign used     = m_tdata[74:67];

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (status == ST_OK || status == ST_FAIL || status == ST_EOF)
                     && m_tdata[79:75] == 5'd0)
        else $error("bad status code or pad bits");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status != ST_OK |-> m_tdata[63:0] == 64'd0)
        else $error("failed field carries a value");

    a_eof_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == ST_EOF |-> used == 8'd0 && !consumed)
        else $error("end-of-input result counts characters");

    a_ok_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == ST_OK |-> used != 8'd0)
        else $error("converted field with no characters");

endmodule

bind ascii_integer_field_parser_unit aifp_checker u_aifp_checker (.*);
